### sv/itpc_pkg.sv
// Shared types, symbol codes and lookup functions for the infix to postfix converter.
`timescale 1ns / 1ps

package itpc_pkg;

   localparam int CODE_W = 3;
   localparam int STATUS_W = 3;

   typedef logic [CODE_W-1:0] code_type;
   typedef logic [STATUS_W-1:0] status_type;

   // Stack entry codes
   localparam code_type CODE_OPEN = 3'd0;
   localparam code_type CODE_ADD  = 3'd1;
   localparam code_type CODE_SUB  = 3'd2;
   localparam code_type CODE_MUL  = 3'd3;
   localparam code_type CODE_DIV  = 3'd4;
   localparam code_type CODE_POW  = 3'd5;

   // Result status codes
   localparam status_type ST_OK        = 3'd0;
   localparam status_type ST_INVALID   = 3'd1;
   localparam status_type ST_UNMATCHED = 3'd2;
   localparam status_type ST_UNCLOSED  = 3'd3;
   localparam status_type ST_FULL      = 3'd4;

   // ASCII characters
   localparam logic [7:0] CHAR_OPEN  = 8'h28;
   localparam logic [7:0] CHAR_CLOSE = 8'h29;
   localparam logic [7:0] CHAR_MUL   = 8'h2A;
   localparam logic [7:0] CHAR_ADD   = 8'h2B;
   localparam logic [7:0] CHAR_SUB   = 8'h2D;
   localparam logic [7:0] CHAR_DIV   = 8'h2F;
   localparam logic [7:0] CHAR_POW   = 8'h5E;

   // Stack command from the sequencer
   typedef struct packed {
      logic     push;
      logic     pop;
      logic     reseed;
      code_type code;
   } stk_op_type;

   // Stack status toward the sequencer
   typedef struct packed {
      logic     empty;
      logic     single;
      logic     pair;
      logic     full;
      code_type top;
      code_type below;
   } stk_stat_type;

   function automatic code_type sym_to_code(input logic [7:0] sym);
      code_type c;
      case (sym)
         CHAR_ADD: c = CODE_ADD;
         CHAR_SUB: c = CODE_SUB;
         CHAR_MUL: c = CODE_MUL;
         CHAR_DIV: c = CODE_DIV;
         CHAR_POW: c = CODE_POW;
         default:  c = CODE_OPEN;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] code_char(input code_type c);
      logic [7:0] ch;
      case (c)
         CODE_OPEN: ch = CHAR_OPEN;
         CODE_ADD:  ch = CHAR_ADD;
         CODE_SUB:  ch = CHAR_SUB;
         CODE_MUL:  ch = CHAR_MUL;
         CODE_DIV:  ch = CHAR_DIV;
         CODE_POW:  ch = CHAR_POW;
         default:   ch = 8'h00;
      endcase
      return ch;
   endfunction

   function automatic logic [1:0] code_prec(input code_type c);
      logic [1:0] p;
      case (c)
         CODE_ADD: p = 2'd1;
         CODE_SUB: p = 2'd1;
         CODE_MUL: p = 2'd2;
         CODE_DIV: p = 2'd2;
         CODE_POW: p = 2'd3;
         default:  p = 2'd0;
      endcase
      return p;
   endfunction

   function automatic logic is_alnum(input logic [7:0] sym);
      return (sym >= 8'h30 && sym <= 8'h39) || (sym >= 8'h41 && sym <= 8'h5A) ||
             (sym >= 8'h61 && sym <= 8'h7A);
   endfunction

endpackage

### sv/itpc_stack.sv
// Operator stack: top entry in a register, the rest in a memory with a prefetched second entry.
`timescale 1ns / 1ps

module itpc_stack #(
   parameter int DEPTH = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  itpc_pkg::stk_op_type   op,
   output itpc_pkg::stk_stat_type stat
);
   import itpc_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);
   localparam int AW = $clog2(DEPTH);

   code_type          mem [DEPTH];
   logic [CW-1:0]     count_ff, count_in;
   code_type          top_ff, top_in;
   code_type          below_ff;
   logic [CW-1:0]     wr_idx, rd_idx;
   logic [AW-1:0]     wr_addr, rd_addr;
   logic              wr_en;

   always_comb begin
      count_in = count_ff;
      top_in   = top_ff;
      if (op.reseed) begin
         count_in = CW'(1);
         top_in   = CODE_OPEN;
      end else if (op.push) begin
         count_in = count_ff + CW'(1);
         top_in   = op.code;
      end else if (op.pop) begin
         count_in = count_ff - CW'(1);
         top_in   = below_ff;
      end
   end

   // Spill the old top below the new one on a push
   assign wr_en   = op.push && !op.reseed && (count_ff != '0);
   assign wr_idx  = count_ff - CW'(1);
   assign rd_idx  = count_in - CW'(2);
   assign wr_addr = wr_idx[AW-1:0];
   assign rd_addr = rd_idx[AW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= CW'(1);
         top_ff   <= CODE_OPEN;
      end else begin
         count_ff <= count_in;
         top_ff   <= top_in;
      end
   end

   // Keep the entry under the top ready; bypass the spilled top on a push
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= top_ff;
         below_ff     <= top_ff;
      end else begin
         below_ff     <= mem[rd_addr];
      end
   end

   assign stat.empty  = (count_ff == '0);
   assign stat.single = (count_ff == CW'(1));
   assign stat.pair   = (count_ff == CW'(2));
   assign stat.full   = (count_ff == CW'(DEPTH));
   assign stat.top    = top_ff;
   assign stat.below  = below_ff;

endmodule

### sv/itpc_seq.sv
// Sequencer: classifies each symbol, drives the precedence compare and pop loop, holds the result register.
`timescale 1ns / 1ps

module itpc_seq (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [7:0]             req_tdata,
   input  logic                   req_tlast,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [7:0]             rsp_tdata,
   output logic [2:0]             rsp_tuser,
   output logic                   rsp_tlast,
   output itpc_pkg::stk_op_type   stk_op,
   input  itpc_pkg::stk_stat_type stk_stat
);
   import itpc_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_DISPATCH,
      S_OPER,
      S_CLOSE
   } state_type;

   state_type   state_ff, state_in;
   logic        err_ff, err_in;
   logic [7:0]  sym_ff, sym_in;
   logic        fin_ff, fin_in;
   code_type    code_ff, code_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_sym_ff, rsp_sym_in;
   status_type  rsp_status_ff, rsp_status_in;
   logic        rsp_last_ff, rsp_last_in;

   logic        can_emit;
   logic        emit;
   logic [7:0]  e_sym;
   status_type  e_status;
   logic        e_last;
   logic [1:0]  prec_cur;
   logic        top_stops, below_stops;

   assign can_emit    = !rsp_valid_ff || rsp_tready;
   assign prec_cur    = code_prec(code_ff);
   // Precedence compares: does the top or next stacked operator stop the pop loop?
   assign top_stops   = (stk_stat.top == CODE_OPEN) || (code_prec(stk_stat.top) < prec_cur);
   assign below_stops = (stk_stat.below == CODE_OPEN) || (code_prec(stk_stat.below) < prec_cur);

   always_comb begin
      state_in = state_ff;
      err_in   = err_ff;
      sym_in   = sym_ff;
      fin_in   = fin_ff;
      code_in  = code_ff;
      emit     = 1'b0;
      e_sym    = 8'h00;
      e_status = ST_OK;
      e_last   = 1'b0;
      stk_op   = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               sym_in   = req_tdata;
               fin_in   = req_tlast;
               code_in  = sym_to_code(req_tdata);
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            if (fin_ff) begin
               if (err_ff) begin
                  stk_op.reseed = 1'b1;
                  err_in        = 1'b0;
                  state_in      = S_IDLE;
               end else begin
                  state_in = S_CLOSE;
               end
            end else if (err_ff) begin
               state_in = S_IDLE;
            end else if (sym_ff == CHAR_OPEN) begin
               if (stk_stat.full) begin
                  if (can_emit) begin
                     emit     = 1'b1;
                     e_status = ST_FULL;
                     e_last   = 1'b1;
                     err_in   = 1'b1;
                     state_in = S_IDLE;
                  end
               end else begin
                  stk_op.push = 1'b1;
                  stk_op.code = CODE_OPEN;
                  state_in    = S_IDLE;
               end
            end else if (is_alnum(sym_ff)) begin
               if (can_emit) begin
                  emit     = 1'b1;
                  e_sym    = sym_ff;
                  e_last   = 1'b1;
                  state_in = S_IDLE;
               end
            end else if (code_ff != CODE_OPEN) begin
               state_in = S_OPER;
            end else if (sym_ff == CHAR_CLOSE) begin
               state_in = S_CLOSE;
            end else if (can_emit) begin
               emit     = 1'b1;
               e_status = ST_INVALID;
               e_last   = 1'b1;
               err_in   = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_OPER: begin
            if (stk_stat.empty) begin
               if (can_emit) begin
                  emit     = 1'b1;
                  e_status = ST_UNMATCHED;
                  e_last   = 1'b1;
                  err_in   = 1'b1;
                  state_in = S_IDLE;
               end
            end else if (top_stops) begin
               if (stk_stat.full) begin
                  if (can_emit) begin
                     emit     = 1'b1;
                     e_status = ST_FULL;
                     e_last   = 1'b1;
                     err_in   = 1'b1;
                     state_in = S_IDLE;
                  end
               end else begin
                  stk_op.push = 1'b1;
                  stk_op.code = code_ff;
                  state_in    = S_IDLE;
               end
            end else if (can_emit) begin
               // Last when the next entry stops the loop and the push then fits
               emit       = 1'b1;
               e_sym      = code_char(stk_stat.top);
               e_last     = !stk_stat.single && below_stops;
               stk_op.pop = 1'b1;
            end
         end
         S_CLOSE: begin
            if (stk_stat.empty) begin
               if (can_emit) begin
                  emit     = 1'b1;
                  e_status = ST_UNMATCHED;
                  e_last   = 1'b1;
                  err_in   = !fin_ff;
                  stk_op.reseed = fin_ff;
                  state_in = S_IDLE;
               end
            end else if (stk_stat.top == CODE_OPEN) begin
               if (fin_ff) begin
                  if (!stk_stat.single) begin
                     if (can_emit) begin
                        emit          = 1'b1;
                        e_status      = ST_UNCLOSED;
                        e_last        = 1'b1;
                        err_in        = 1'b0;
                        stk_op.reseed = 1'b1;
                        state_in      = S_IDLE;
                     end
                  end else begin
                     err_in        = 1'b0;
                     stk_op.reseed = 1'b1;
                     state_in      = S_IDLE;
                  end
               end else begin
                  stk_op.pop = 1'b1;
                  state_in   = S_IDLE;
               end
            end else if (can_emit) begin
               emit       = 1'b1;
               e_sym      = code_char(stk_stat.top);
               e_last     = !stk_stat.single && (stk_stat.below == CODE_OPEN) &&
                            (!fin_ff || stk_stat.pair);
               stk_op.pop = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_sym_in    = rsp_sym_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      if (emit) begin
         rsp_valid_in  = 1'b1;
         rsp_sym_in    = e_sym;
         rsp_status_in = e_status;
         rsp_last_in   = e_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         err_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sym_ff        <= sym_in;
      fin_ff        <= fin_in;
      code_ff       <= code_in;
      rsp_sym_ff    <= rsp_sym_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_sym_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_no_push_full : assert property (@(posedge clock) disable iff (reset)
      stk_op.push |-> !stk_stat.full)
      else $error("push while stack full");

   a_no_pop_empty : assert property (@(posedge clock) disable iff (reset)
      stk_op.pop |-> !stk_stat.empty)
      else $error("pop while stack empty");

   a_one_stack_op : assert property (@(posedge clock) disable iff (reset)
      $onehot0({stk_op.push, stk_op.pop, stk_op.reseed}))
      else $error("conflicting stack commands");

   a_error_latches : assert property (@(posedge clock) disable iff (reset)
      (emit && (e_status != ST_OK) && !fin_ff) |=> err_ff)
      else $error("error result without latch");

   a_emit_needs_room : assert property (@(posedge clock) disable iff (reset)
      emit |-> can_emit)
      else $error("result overwrote a pending transaction");

endmodule

### sv/infix_to_postfix_converter_top.sv
// Top level of the infix to postfix converter: sequencer plus operator stack.
//
// Usage: send one ASCII character of an infix expression per req_ transaction;
// assert req_tlast on a transaction that ends the expression (its data is
// ignored). Postfix symbols come out on rsp_ with rsp_tuser carrying status
// (0 ok, 1 invalid symbol, 2 unmatched close, 3 unclosed open, 4 stack full)
// and rsp_tlast on the last result of each input transaction. An input may
// produce no result ('(', an operator or ')' popping nothing, or an empty finish).
// Throughput: one item at a time; req_tready is high only while idle.
// An operand or '(' is handled in the dispatch state; results are registered.
// An operator, ')' or finish goes on from dispatch to a pop loop that runs one
// stack entry per cycle when rsp_tready allows; operators pop by precedence.
// After an error, non-finish inputs are dropped until the next finish.
// Reset (synchronous) leaves the stack holding only the opening sentinel.
// A stalled rsp_tready holds the pending result and freezes the pop loop;
// the block keeps going as soon as the output register frees up.
`timescale 1ns / 1ps

module infix_to_postfix_converter_top #(
   parameter int STACK_DEPTH = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] symbol
   input  logic       req_tlast,   // finish
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_symbol
   output logic [2:0] rsp_tuser,   // [2:0] status
   output logic       rsp_tlast    // last
);
   import itpc_pkg::*;

   stk_op_type   stk_op;
   stk_stat_type stk_stat;

   itpc_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .stk_op     (stk_op),
      .stk_stat   (stk_stat)
   );

   itpc_stack #(
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock (clock),
      .reset (reset),
      .op    (stk_op),
      .stat  (stk_stat)
   );

endmodule
